// ===== src/cdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

    localparam int unsigned YearW  = 12;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned DoyW   = 9;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } date_t;

    typedef logic [2:0] op_t;
    typedef logic [1:0] order_t;

    localparam op_t OP_SET        = 3'd0;
    localparam op_t OP_NEXT_DAY   = 3'd1;
    localparam op_t OP_NEXT_MONTH = 3'd2;
    localparam op_t OP_NEXT_YEAR  = 3'd3;
    localparam op_t OP_PREV_YEAR  = 3'd4;
    localparam op_t OP_COMPARE    = 3'd5;

    localparam order_t ORD_EQUAL   = 2'd0;
    localparam order_t ORD_EARLIER = 2'd1;
    localparam order_t ORD_LATER   = 2'd2;

    localparam logic [MonthW-1:0] JANUARY  = 4'd1;
    localparam logic [MonthW-1:0] FEBRUARY = 4'd2;
    localparam logic [MonthW-1:0] DECEMBER = 4'd12;

    // inverse of 25 modulo 2**12: y is a multiple of 25 iff y*inv mod 4096 <= 4095/25
    localparam logic [YearW-1:0] Inv25    = 12'd3113;
    localparam logic [YearW-1:0] Div25Max = 12'd163;

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [2*YearW-1:0] prod;
        logic               div25;
        prod  = y * Inv25;
        div25 = (prod[YearW-1:0] <= Div25Max);
        // by 400 means by 16 and 25; by 100 means by 4 and 25
        return (div25 && (y[3:0] == 4'd0)) || (!div25 && (y[1:0] == 2'd0));
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
        logic [DoyW-1:0] d;
        unique case (m)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            default:    d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/cdr_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdr_step #(
    parameter int unsigned MIN_VALID_YEAR = 1970,
    parameter int unsigned MAX_VALID_YEAR = 2035
) (
    input  cdr_pkg::date_t              cur,
    input  cdr_pkg::op_t                op,
    input  cdr_pkg::date_t              in_date,
    output cdr_pkg::date_t              nxt,
    output logic [cdr_pkg::DoyW-1:0]    doy,
    output logic                        acc,
    output cdr_pkg::order_t             ord
);
    import cdr_pkg::*;

    localparam logic [YearW-1:0] MinYear = YearW'(MIN_VALID_YEAR);
    localparam logic [YearW-1:0] MaxYear = YearW'(MAX_VALID_YEAR);

    logic [YearW-1:0] year_inc;
    logic [YearW-1:0] year_dec;
    logic             leap_cur;
    logic             leap_inc;
    logic             leap_dec;
    logic             leap_in;
    logic             leap_new;
    logic             set_ok;
    logic [DayW-1:0]  cur_len;
    logic [DayW-1:0]  new_len;
    logic [MonthW-1:0] month_inc;
    logic             feb29;

    assign year_inc  = cur.year + 1'b1;
    assign year_dec  = cur.year - 1'b1;
    assign leap_cur  = is_leap(cur.year);
    assign leap_inc  = is_leap(year_inc);
    assign leap_dec  = is_leap(year_dec);
    assign leap_in   = is_leap(in_date.year);
    assign cur_len   = month_len(cur.month, leap_cur);
    assign month_inc = (cur.month >= DECEMBER) ? JANUARY : cur.month + 1'b1;
    // month only becomes february within the same year, so the current leap flag serves
    assign new_len   = month_len(month_inc, leap_cur);
    assign feb29     = (cur.month == FEBRUARY) && (cur.day == 5'd29);

    assign set_ok = (in_date.year >= MinYear) && (in_date.year <= MaxYear)
                 && (in_date.month >= JANUARY) && (in_date.month <= DECEMBER)
                 && (in_date.day != '0)
                 && (in_date.day <= month_len(in_date.month, leap_in));

    always_comb
    begin
        nxt      = cur;
        acc      = 1'b1;
        ord      = ORD_EQUAL;
        leap_new = leap_cur;
        unique case (op)
            OP_SET:
            begin
                if (set_ok)
                begin
                    nxt      = in_date;
                    leap_new = leap_in;
                end
                else
                begin
                    acc = 1'b0;
                end
            end
            OP_NEXT_DAY:
            begin
                if (cur.day >= cur_len)
                begin
                    nxt.day   = 5'd1;
                    nxt.month = month_inc;
                    if (cur.month >= DECEMBER)
                    begin
                        nxt.year = year_inc;
                    end
                end
                else
                begin
                    nxt.day = cur.day + 1'b1;
                end
            end
            OP_NEXT_MONTH:
            begin
                nxt.month = month_inc;
                if (cur.month >= DECEMBER)
                begin
                    nxt.year = year_inc;
                end
                if (cur.day > new_len)
                begin
                    nxt.day = new_len;
                end
            end
            OP_NEXT_YEAR:
            begin
                nxt.year = year_inc;
                leap_new = leap_inc;
                if (feb29)
                begin
                    nxt.day = 5'd28;
                end
            end
            OP_PREV_YEAR:
            begin
                nxt.year = year_dec;
                leap_new = leap_dec;
                if (feb29)
                begin
                    nxt.day = 5'd28;
                end
            end
            OP_COMPARE:
            begin
                priority if (cur.year != in_date.year)
                begin
                    ord = (cur.year < in_date.year) ? ORD_EARLIER : ORD_LATER;
                end
                else if (cur.month != in_date.month)
                begin
                    ord = (cur.month < in_date.month) ? ORD_EARLIER : ORD_LATER;
                end
                else if (cur.day != in_date.day)
                begin
                    ord = (cur.day < in_date.day) ? ORD_EARLIER : ORD_LATER;
                end
                else
                begin
                    ord = ORD_EQUAL;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // a year change only reaches january in the stepping ops, so leap_new is exact where it matters
    assign doy = days_before(nxt.month) + DoyW'(nxt.day)
               + DoyW'((nxt.month > FEBRUARY) && leap_new);

endmodule

`default_nettype wire

// ===== src/calendar_date_register_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_ready  | operation, in_year, in_month, in_day
// out     | out_valid / out_ready| out_year, out_month, out_day, day_of_year,
//         |                      | accepted, order
//
// one item per cycle while the output is not stalled; a result passes the input register,
// then the date and result registers
// reset gives 1970-01-01 and empties both stages
// a stalled output holds the result; the input register still takes one more item

module calendar_date_register_top #(
    parameter int unsigned MIN_VALID_YEAR = 1970,
    parameter int unsigned MAX_VALID_YEAR = 2035
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    operation,
    input  logic [cdr_pkg::YearW-1:0]     in_year,
    input  logic [cdr_pkg::MonthW-1:0]    in_month,
    input  logic [cdr_pkg::DayW-1:0]      in_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cdr_pkg::YearW-1:0]     out_year,
    output logic [cdr_pkg::MonthW-1:0]    out_month,
    output logic [cdr_pkg::DayW-1:0]      out_day,
    output logic [cdr_pkg::DoyW-1:0]      day_of_year,
    output logic                          accepted,
    output logic [1:0]                    order
);
    import cdr_pkg::*;

    logic            stage_valid_reg;
    op_t             op_reg;
    date_t           in_date_reg;
    date_t           cur_reg;
    logic            out_valid_reg;
    logic [DoyW-1:0] doy_reg;
    logic            acc_reg;
    order_t          ord_reg;

    date_t           cur_next;
    logic [DoyW-1:0] doy_next;
    logic            acc_next;
    order_t          ord_next;
    logic            advance;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    cdr_step #(
        .MIN_VALID_YEAR (MIN_VALID_YEAR),
        .MAX_VALID_YEAR (MAX_VALID_YEAR)
    ) u_step (
        .cur     (cur_reg),
        .op      (op_reg),
        .in_date (in_date_reg),
        .nxt     (cur_next),
        .doy     (doy_next),
        .acc     (acc_next),
        .ord     (ord_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            cur_reg.year    <= 12'd1970;
            cur_reg.month   <= JANUARY;
            cur_reg.day     <= 5'd1;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg            <= operation;
            in_date_reg.year  <= in_year;
            in_date_reg.month <= in_month;
            in_date_reg.day   <= in_day;
        end
        if (advance)
        begin
            doy_reg <= doy_next;
            acc_reg <= acc_next;
            ord_reg <= ord_next;
        end
    end

    // the stored date only moves when the output is free, so it is the shown result
    assign out_valid   = out_valid_reg;
    assign out_year    = cur_reg.year;
    assign out_month   = cur_reg.month;
    assign out_day     = cur_reg.day;
    assign day_of_year = doy_reg;
    assign accepted    = acc_reg;
    assign order       = ord_reg;

endmodule

`default_nettype wire
